@@ hw/rtl/bswr_pkg.sv @@
`default_nettype none
package bswr_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int CAP_W   = 5;
  localparam int OCNT_W  = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

  localparam logic [DATA_W-1:0] EMPTY_READ = {DATA_W{1'b1}};

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] read_value;
    logic              hit;
    logic [CNT_W-1:0]  entry_count;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/bswr_ram.sv @@
`default_nettype none
module bswr_ram
  import bswr_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_wr_t           wr,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/bswr_ctrl.sv @@
`default_nettype none
module bswr_ctrl
  import bswr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire logic [CNT_W-1:0]  cap_eff,
  input  wire logic [DATA_W-1:0] rdata,
  output logic                   busy,
  output ram_wr_t                wr,
  output logic      [IDX_W-1:0]  raddr,
  output res_t                   res
);

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [ST_W-1:0] ST_READ  = 2'd1;
  localparam logic [ST_W-1:0] ST_SRCH  = 2'd2;
  localparam logic [ST_W-1:0] ST_SHIFT = 2'd3;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              pop_r, pop_nxt;
  logic [CNT_W-1:0]  idx_p1;
  logic [IDX_W-1:0]  top_idx;

  assign idx_p1  = {{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(1);
  assign top_idx = IDX_W'(count_r - CNT_W'(1));
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    pop_nxt   = pop_r;
    wr        = '0;
    raddr     = idx_r + IDX_W'(1);
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        raddr = (in_kind == KIND_REMOVE) ? '0 : top_idx;
        if (start) begin
          val_nxt = in_value;
          pop_nxt = (in_kind == KIND_POP);
          idx_nxt = '0;
          case (in_kind)
            KIND_PUSH: begin
              res.valid = 1'b1;
              if (count_r < cap_eff) begin
                wr.we     = 1'b1;
                wr.addr   = IDX_W'(count_r);
                wr.data   = in_value;
                count_nxt = count_r + CNT_W'(1);
                res.hit   = 1'b1;
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (count_r == '0) begin
                res.valid      = 1'b1;
                res.read_value = EMPTY_READ;
              end else begin
                state_nxt = ST_READ;
              end
            end
            KIND_REMOVE: begin
              if (count_r == '0) begin
                res.valid = 1'b1;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res.valid      = 1'b1;
        res.hit        = 1'b1;
        res.read_value = rdata;
        if (pop_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_SRCH: begin
        if (rdata == val_r) begin
          state_nxt = ST_SHIFT;
        end else if (idx_p1 >= count_r) begin
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        raddr = idx_r + IDX_W'(2);
        if (idx_p1 < count_r) begin
          wr.we   = 1'b1;
          wr.addr = idx_r;
          wr.data = rdata;
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          res.valid = 1'b1;
          res.hit   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    res.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    pop_r <= pop_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/bounded_stack_with_remove_core.sv @@
// Push, or any request on an empty stack: result in the cycle after the transfer.
// Pop and peek: read state, then output register. Remove: the search state reads
// entries from the bottom until one matches, then the shift state moves each later
// entry down one place; a search with no match ends with hit low. busy is high
// until the result. Results cannot be stalled. Synchronous reset empties the stack
// and sets the capacity to its full value; stored words are not cleared.
`default_nettype none
module bounded_stack_with_remove_core
  import bswr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [KIND_W-1:0] in_kind,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     cfg_we,
  input  wire logic        [CAP_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_read_value,
  output logic                          out_hit,
  output logic             [OCNT_W-1:0] out_entry_count,
  output logic                          out_is_full,
  output logic                          out_is_empty
);

  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_eff;
  ram_wr_t           wr;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  res_t              res;

  logic              valid_r;
  logic [DATA_W-1:0] read_value_r;
  logic              hit_r;
  logic [CNT_W-1:0]  count_r;
  logic              full_r;
  logic              empty_r;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  bswr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_kind  (in_kind),
    .in_value (in_value),
    .cap_eff  (cap_eff),
    .rdata    (rdata),
    .busy     (busy),
    .wr       (wr),
    .raddr    (raddr),
    .res      (res)
  );

  bswr_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_W'(DEPTH > 16 ? 16 : DEPTH);
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    read_value_r <= res.read_value;
    hit_r        <= res.hit;
    count_r      <= res.entry_count;
    full_r       <= (res.entry_count >= cap_eff);
    empty_r      <= (res.entry_count == '0);
  end

  assign out_valid       = valid_r;
  assign out_read_value  = read_value_r;
  assign out_hit         = hit_r;
  assign out_entry_count = OCNT_W'(count_r);
  assign out_is_full     = full_r;
  assign out_is_empty    = empty_r;

  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_PUSH) |=> out_valid)
    else $error("push transfer did not give a result in the next cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("block still busy when its result is shown");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_full && out_is_empty))
    else $error("full and empty reported together");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit && out_read_value != 0) |-> out_is_empty)
    else $error("empty read value reported on a stack holding entries");

endmodule
`default_nettype wire

@@ verif/tb_bounded_stack_with_remove_core.sv @@
module tb_bounded_stack_with_remove_core;
  import bswr_pkg::*;

  localparam int SETTLE = 3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 24;
  localparam int OPS_PER_PHASE = 60;

  typedef struct {
    bit                is_cfg;
    bit                drain;
    int                gap;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [CAP_W-1:0]  cap;
  } stack_op_t;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    logic              hit;
    logic [OCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } stack_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic        [KIND_W-1:0] in_kind = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     cfg_we = 1'b0;
  logic        [CAP_W-1:0]  cfg_wdata = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_hit;
  logic        [OCNT_W-1:0] out_entry_count;
  logic                     out_is_full;
  logic                     out_is_empty;

  stack_op_t   pending_ops[$];
  stack_resp_t awaited_results[$];
  stack_op_t   cur_op;
  bit          have_op = 1'b0;
  int          quiet_cycles = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;
  int          gap_mode = 1;

  logic [DATA_W-1:0] model_mem [DEPTH];
  int unsigned       model_top = 0;
  logic [CAP_W-1:0]  model_cap = CAP_W'(DEPTH);

  bounded_stack_with_remove_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_hit         (out_hit),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stack_resp_t stack_apply(logic [KIND_W-1:0] kind,
                                              logic [DATA_W-1:0] value);
    stack_resp_t r;
    int unsigned lim;
    int unsigned i;
    lim = (model_cap == 0) ? 1 : ((model_cap > DEPTH) ? DEPTH : model_cap);
    r.read_value = '0;
    r.hit = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (model_top < lim) begin
          model_mem[model_top] = value;
          model_top++;
          r.hit = 1'b1;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (model_top == 0) begin
          r.read_value = EMPTY_READ;
        end else begin
          r.read_value = model_mem[model_top - 1];
          r.hit = 1'b1;
          if (kind == KIND_POP) model_top--;
        end
      end
      default: begin
        i = 0;
        while (i < model_top && model_mem[i] !== value) i++;
        if (i < model_top) begin
          while (i + 1 < model_top) begin
            model_mem[i] = model_mem[i + 1];
            i++;
          end
          model_top--;
          r.hit = 1'b1;
        end
      end
    endcase
    r.count = OCNT_W'(model_top);
    r.full = (model_top >= lim);
    r.empty = (model_top == 0);
    return r;
  endfunction

  function automatic int draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  task automatic add_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value, bit drain);
    stack_op_t op;
    op.is_cfg = 1'b0;
    op.drain = drain;
    op.gap = draw_gap();
    op.kind = kind;
    op.value = value;
    op.cap = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_cap(logic [CAP_W-1:0] cap);
    stack_op_t op;
    op.is_cfg = 1'b1;
    op.drain = 1'b1;
    op.gap = draw_gap();
    op.kind = KIND_PUSH;
    op.value = '0;
    op.cap = cap;
    pending_ops.push_back(op);
  endtask

  always @(posedge clk) begin : drive
    bit accepted;
    bit start_next;
    bit we_next;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        awaited_results.push_back(stack_apply(in_kind, in_value));
        have_op = 1'b0;
      end
      start_next = start && !accepted;
      we_next = 1'b0;
      if (awaited_results.size() == 0 && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!have_op && pending_ops.size() != 0) begin
        cur_op = pending_ops.pop_front();
        have_op = 1'b1;
      end
      if (have_op && !start_next) begin
        if (cur_op.gap > 0) begin
          cur_op.gap--;
        end else if (!((cur_op.is_cfg || cur_op.drain) && quiet_cycles < SETTLE)) begin
          if (cur_op.is_cfg) begin
            we_next = 1'b1;
            cfg_wdata <= cur_op.cap;
            model_cap = cur_op.cap;
            have_op = 1'b0;
            quiet_cycles = 0;
          end else begin
            start_next = 1'b1;
            in_kind <= cur_op.kind;
            in_value <= cur_op.value;
          end
        end
      end
      start <= start_next;
      cfg_we <= we_next;
    end
  end

  always @(posedge clk) begin : monitor
    stack_resp_t e;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("Result transfer with no operation outstanding");
        fail_count++;
      end else begin
        e = awaited_results.pop_front();
        if (out_read_value !== e.read_value) begin
          $error("read_value: expected %0d, got %0d", $signed(e.read_value), out_read_value);
          fail_count++;
        end
        if (out_hit !== e.hit) begin
          $error("hit: expected %0b, got %0b", e.hit, out_hit);
          fail_count++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_entry_count);
          fail_count++;
        end
        if (out_is_full !== e.full) begin
          $error("is_full: expected %0b, got %0b", e.full, out_is_full);
          fail_count++;
        end
        if (out_is_empty !== e.empty) begin
          $error("is_empty: expected %0b, got %0b", e.empty, out_is_empty);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [DATA_W-1:0] pool [6];
    logic [CAP_W-1:0]  cap;
    logic [DATA_W-1:0] v;
    int                push_w;
    int                r;

    // Directed part: empty reads, extreme words, duplicates, full and lowered capacity.
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_PEEK, 32'd0, 1'b0);
    add_op(KIND_REMOVE, 32'd7, 1'b0);
    add_op(KIND_PUSH, 32'h8000_0000, 1'b0);
    add_op(KIND_PUSH, 32'h7fff_ffff, 1'b0);
    add_op(KIND_PUSH, 32'hffff_ffff, 1'b0);
    add_op(KIND_PUSH, 32'h0000_0000, 1'b0);
    add_op(KIND_PUSH, 32'hffff_ffff, 1'b0);
    add_op(KIND_PEEK, 32'd0, 1'b0);
    add_op(KIND_REMOVE, 32'hffff_ffff, 1'b0);
    add_op(KIND_REMOVE, 32'd12345, 1'b0);
    add_op(KIND_REMOVE, 32'h8000_0000, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_cap(5'd2);
    add_op(KIND_PUSH, 32'd1, 1'b0);
    add_op(KIND_PUSH, 32'd2, 1'b0);
    add_op(KIND_PUSH, 32'd3, 1'b0);
    add_cap(5'd1);
    add_op(KIND_PUSH, 32'd4, 1'b0);
    add_op(KIND_REMOVE, 32'd1, 1'b0);
    add_op(KIND_PEEK, 32'd0, 1'b0);
    add_cap(5'd0);
    add_op(KIND_PUSH, 32'd5, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_PUSH, 32'd6, 1'b0);
    add_cap(5'd31);
    add_op(KIND_PUSH, 32'd7, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 5'd16;
        1: cap = 5'd1;
        2: cap = 5'd0;
        3: cap = 5'd31;
        4: cap = 5'd17;
        5: cap = 5'd2;
        6: cap = 5'd15;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      gap_mode = $urandom_range(0, 2);
      add_cap(cap);
      for (int k = 0; k < 6; k++) begin
        r = $urandom_range(0, 5);
        case (r)
          0: pool[k] = 32'h8000_0000;
          1: pool[k] = 32'h7fff_ffff;
          2: pool[k] = 32'hffff_ffff;
          default: pool[k] = $urandom;
        endcase
      end
      push_w = (p % 4 == 0) ? 8 : $urandom_range(3, 7);
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        v = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 5)];
        r = $urandom_range(0, 9);
        if (r < push_w) add_op(KIND_PUSH, v, $urandom_range(0, 99) == 0);
        else add_op(KIND_W'($urandom_range(1, 3)), v, $urandom_range(0, 99) == 0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() == 0 && !have_op);
    @(posedge clk);
    while (start || busy || awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
